// File: rtl/lhsm_pkg.sv
package lhsm_pkg;

  localparam int unsigned LatW            = 64;
  localparam int unsigned SubBucketBitsDef = 5;

  typedef enum logic [2:0] {
    OP_BEGIN    = 3'd0,
    OP_END      = 3'd1,
    OP_SNAP_ALL = 3'd2,
    OP_SNAP_WIN = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_IDX,
    ST_HRD,
    ST_HWR,
    ST_SUM,
    ST_SUM_TAIL,
    ST_SRCH,
    ST_SRCH_TAIL1,
    ST_SRCH_TAIL2,
    ST_DONE,
    ST_CLR
  } state_e;

  typedef struct packed {
    logic [LatW-1:0] begin_count;
    logic [LatW-1:0] good_count;
    logic [LatW-1:0] bad_count;
    logic [LatW-1:0] in_flight;
    logic [LatW-1:0] min_latency;
    logic [LatW-1:0] max_latency;
    logic [LatW-1:0] latency_sum;
    logic [LatW-1:0] p99_bound_ns;
  } result_t;

endpackage

// File: rtl/lhsm_in_if.sv
interface lhsm_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    operation;
  logic [lhsm_pkg::LatW-1:0]     latency_ns;
  logic                          failed;

  modport source (output valid, operation, latency_ns, failed, input ready);
  modport sink   (input valid, operation, latency_ns, failed, output ready);
endinterface

// File: rtl/lhsm_out_if.sv
interface lhsm_out_if;
  logic                          valid;
  logic                          ready;
  logic [lhsm_pkg::LatW-1:0]     begin_count;
  logic [lhsm_pkg::LatW-1:0]     good_count;
  logic [lhsm_pkg::LatW-1:0]     bad_count;
  logic [lhsm_pkg::LatW-1:0]     in_flight;
  logic [lhsm_pkg::LatW-1:0]     min_latency;
  logic [lhsm_pkg::LatW-1:0]     max_latency;
  logic [lhsm_pkg::LatW-1:0]     latency_sum;
  logic [lhsm_pkg::LatW-1:0]     p99_bound_ns;

  modport source (output valid, begin_count, good_count, bad_count, in_flight, min_latency,
                  max_latency, latency_sum, p99_bound_ns, input ready);
  modport sink   (input valid, begin_count, good_count, bad_count, in_flight, min_latency,
                  max_latency, latency_sum, p99_bound_ns, output ready);
endinterface

// File: rtl/lhsm_ram.sv
module lhsm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1920
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/latency_histogram_stats_monitor_top.sv
// Latency monitor for one trace point: begin/good/bad counts, min, max and sum of good
// latencies, for all time and for the current interval, plus two log-linear histograms
// of 2^SUB_BUCKET_BITS * (65 - SUB_BUCKET_BITS) buckets (1920 by default) held in two
// single-port-read RAMs. After reset the block zeroes both RAMs, one bucket a cycle,
// before it takes the first transfer. Begin, failed end, unknown codes, and clears and good
// ends while inactive go straight back to idle; a good end while active forms the bucket
// index, then does a read-modify-write of both histograms. A snapshot while active walks
// the histogram twice, once for the total and once for the 99th percentile search; while
// inactive it goes straight to the result. A clear while active zeroes both RAMs in one
// bucket-per-cycle sweep. A result sits in an output register, so the next item may be
// taken while it waits; a further snapshot waits at its end for that register.
module latency_histogram_stats_monitor_top #(
  parameter int unsigned SUB_BUCKET_BITS = lhsm_pkg::SubBucketBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  lhsm_in_if.sink    in_i,
  lhsm_out_if.source out_o
);

  localparam int unsigned W       = lhsm_pkg::LatW;
  localparam int unsigned SubCnt  = 1 << SUB_BUCKET_BITS;
  localparam int unsigned Buckets = SubCnt * (65 - SUB_BUCKET_BITS);
  localparam int unsigned IW      = $clog2(Buckets);
  localparam int unsigned EW      = 6;
  localparam int unsigned PW      = W + 7;
  localparam logic [IW-1:0] LastIdx = IW'(Buckets - 1);

  function automatic logic [EW-1:0] top_bit(input logic [W-1:0] v);
    logic [EW-1:0] e;
    e = '0;
    for (int i = 1; i < W; i++) begin
      if (v[i]) e = EW'(i);
    end
    return e;
  endfunction

  function automatic logic [W-1:0] bucket_top(input logic [IW-1:0] idx);
    logic [IW-1:0] rel;
    logic [IW-1:0] grp;
    logic [IW-1:0] sub;
    logic [W-1:0]  base;
    if (idx < IW'(SubCnt)) return W'(idx);
    rel  = idx - IW'(SubCnt);
    grp  = rel >> SUB_BUCKET_BITS;
    sub  = rel & IW'(SubCnt - 1);
    if ((32'(grp) + SUB_BUCKET_BITS >= 63) && (sub == IW'(SubCnt - 1))) return '1;
    base = W'(SubCnt) + W'(sub) + W'(1);
    return (base << grp) - W'(1);
  endfunction

  lhsm_pkg::state_e state_q, state_d;

  logic          active_q;
  logic [W-1:0]  a_beg_q, a_good_q, a_bad_q, a_sum_q, a_min_q, a_max_q;
  logic [W-1:0]  w_beg_q, w_good_q, w_bad_q, w_sum_q, w_min_q, w_max_q;
  logic [W-1:0]  lat_q;
  logic [EW-1:0] e_q;
  logic [IW-1:0] hidx_q, hidx_d;
  logic [IW-1:0] ctr_q;
  logic          sel_win_q;
  logic          sel_act_q;
  logic          rv_q, cv_q, found_q;
  logic [IW-1:0] ri_q, ci_q;
  logic [W-1:0]  total_q, cum_q, p99_q;
  lhsm_pkg::result_t snap_q, out_q;
  logic          out_valid_q;

  logic          accept, sweep, out_load, rd_en;
  logic [IW-1:0] raddr;
  logic          we_a, we_w;
  logic [IW-1:0] waddr_a, waddr_w;
  logic [W-1:0]  wdata_a, wdata_w, rdata_a, rdata_w, rdata_sel;
  lhsm_pkg::op_e op;
  logic          ok_end, snap_op;

  assign op       = lhsm_pkg::op_e'(in_i.operation);
  assign accept   = in_i.valid && in_i.ready;
  assign ok_end   = (op == lhsm_pkg::OP_END) && !in_i.failed;
  assign snap_op  = (op == lhsm_pkg::OP_SNAP_ALL) || (op == lhsm_pkg::OP_SNAP_WIN);
  assign sweep    = (state_q == lhsm_pkg::ST_SUM) || (state_q == lhsm_pkg::ST_SRCH) ||
                    (state_q == lhsm_pkg::ST_CLR) || (state_q == lhsm_pkg::ST_INIT);
  assign rdata_sel = sel_win_q ? rdata_w : rdata_a;

  always_comb begin
    hidx_d = IW'(lat_q);
    if (lat_q >= W'(SubCnt)) begin
      hidx_d = ((IW'(e_q) - IW'(SUB_BUCKET_BITS) + IW'(1)) << SUB_BUCKET_BITS) |
               (IW'(lat_q >> (e_q - EW'(SUB_BUCKET_BITS))) & IW'(SubCnt - 1));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lhsm_pkg::ST_INIT, lhsm_pkg::ST_CLR: begin
        if (ctr_q == LastIdx) state_d = lhsm_pkg::ST_IDLE;
      end
      lhsm_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (ok_end && active_q)   state_d = lhsm_pkg::ST_IDX;
          else if (snap_op && active_q)      state_d = lhsm_pkg::ST_SUM;
          else if (snap_op)                  state_d = lhsm_pkg::ST_DONE;
          else if ((op == lhsm_pkg::OP_CLEAR) && active_q) state_d = lhsm_pkg::ST_CLR;
          else                               state_d = lhsm_pkg::ST_IDLE;
        end
      end
      lhsm_pkg::ST_IDX:       state_d = lhsm_pkg::ST_HRD;
      lhsm_pkg::ST_HRD:       state_d = lhsm_pkg::ST_HWR;
      lhsm_pkg::ST_HWR:       state_d = lhsm_pkg::ST_IDLE;
      lhsm_pkg::ST_SUM: begin
        if (ctr_q == LastIdx) state_d = lhsm_pkg::ST_SUM_TAIL;
      end
      lhsm_pkg::ST_SUM_TAIL:  state_d = lhsm_pkg::ST_SRCH;
      lhsm_pkg::ST_SRCH: begin
        if (ctr_q == LastIdx) state_d = lhsm_pkg::ST_SRCH_TAIL1;
      end
      lhsm_pkg::ST_SRCH_TAIL1: state_d = lhsm_pkg::ST_SRCH_TAIL2;
      lhsm_pkg::ST_SRCH_TAIL2: state_d = lhsm_pkg::ST_DONE;
      lhsm_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = lhsm_pkg::ST_IDLE;
      end
      default: state_d = lhsm_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_i.ready = 1'b0;
    out_load   = 1'b0;
    rd_en      = 1'b0;
    raddr      = ctr_q;
    we_a       = 1'b0;
    we_w       = 1'b0;
    waddr_a    = ctr_q;
    waddr_w    = ctr_q;
    wdata_a    = '0;
    wdata_w    = '0;
    unique case (state_q)
      lhsm_pkg::ST_IDLE: in_i.ready = 1'b1;
      lhsm_pkg::ST_INIT, lhsm_pkg::ST_CLR: begin
        we_a = 1'b1;
        we_w = 1'b1;
      end
      lhsm_pkg::ST_HRD: begin
        rd_en = 1'b1;
        raddr = hidx_d;
      end
      lhsm_pkg::ST_HWR: begin
        we_a    = 1'b1;
        we_w    = 1'b1;
        waddr_a = hidx_q;
        waddr_w = hidx_q;
        wdata_a = rdata_a + W'(1);
        wdata_w = rdata_w + W'(1);
      end
      lhsm_pkg::ST_SUM: rd_en = 1'b1;
      lhsm_pkg::ST_SRCH, lhsm_pkg::ST_SRCH_TAIL1: begin
        rd_en   = (state_q == lhsm_pkg::ST_SRCH);
        we_w    = sel_win_q && rv_q;
        waddr_w = ri_q;
      end
      lhsm_pkg::ST_DONE: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  lhsm_ram #(.Width(W), .Depth(Buckets)) u_all_ram (
    .clk_i, .we_i(we_a), .waddr_i(waddr_a), .wdata_i(wdata_a),
    .re_i(rd_en), .raddr_i(raddr), .rdata_o(rdata_a)
  );

  lhsm_ram #(.Width(W), .Depth(Buckets)) u_win_ram (
    .clk_i, .we_i(we_w), .waddr_i(waddr_w), .wdata_i(wdata_w),
    .re_i(rd_en), .raddr_i(raddr), .rdata_o(rdata_w)
  );

  logic [W-1:0] s_beg, s_good, s_bad, s_min, s_fin;
  assign s_beg  = (op == lhsm_pkg::OP_SNAP_WIN) ? w_beg_q  : a_beg_q;
  assign s_good = (op == lhsm_pkg::OP_SNAP_WIN) ? w_good_q : a_good_q;
  assign s_bad  = (op == lhsm_pkg::OP_SNAP_WIN) ? w_bad_q  : a_bad_q;
  assign s_min  = (op == lhsm_pkg::OP_SNAP_WIN) ? w_min_q  : a_min_q;
  assign s_fin  = s_good + s_bad;

  logic          hit;
  logic [W-1:0]  p99_final;
  assign hit = cv_q && !found_q &&
               ((PW'(cum_q) * PW'(100)) >= (PW'(total_q) * PW'(99)));
  assign p99_final = !sel_act_q ? '0 : (total_q == '0) ? '0 : found_q ? p99_q : '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lhsm_pkg::ST_INIT;
      ctr_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      cv_q        <= 1'b0;
      found_q     <= 1'b0;
      a_beg_q <= '0; a_good_q <= '0; a_bad_q <= '0; a_sum_q <= '0;
      a_min_q <= '1; a_max_q <= '0;
      w_beg_q <= '0; w_good_q <= '0; w_bad_q <= '0; w_sum_q <= '0;
      w_min_q <= '1; w_max_q <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= (sweep && ctr_q != LastIdx) ? ctr_q + IW'(1) : '0;
      rv_q    <= rd_en && (state_q != lhsm_pkg::ST_HRD);
      cv_q    <= rv_q && (state_q == lhsm_pkg::ST_SRCH || state_q == lhsm_pkg::ST_SRCH_TAIL1);
      if (hit) found_q <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (accept) begin
        found_q <= 1'b0;
        unique case (op)
          lhsm_pkg::OP_BEGIN: begin
            a_beg_q  <= a_beg_q + W'(1);
            w_beg_q  <= w_beg_q + W'(1);
            active_q <= 1'b1;
          end
          lhsm_pkg::OP_END: begin
            if (in_i.failed) begin
              a_bad_q <= a_bad_q + W'(1);
              w_bad_q <= w_bad_q + W'(1);
            end else begin
              if (in_i.latency_ns < a_min_q) a_min_q <= in_i.latency_ns;
              if (in_i.latency_ns > a_max_q) a_max_q <= in_i.latency_ns;
              if (in_i.latency_ns < w_min_q) w_min_q <= in_i.latency_ns;
              if (in_i.latency_ns > w_max_q) w_max_q <= in_i.latency_ns;
              a_sum_q  <= a_sum_q + in_i.latency_ns;
              w_sum_q  <= w_sum_q + in_i.latency_ns;
              a_good_q <= a_good_q + W'(1);
              w_good_q <= w_good_q + W'(1);
            end
          end
          lhsm_pkg::OP_SNAP_WIN: begin
            w_beg_q <= '0; w_good_q <= '0; w_bad_q <= '0; w_sum_q <= '0;
            w_min_q <= '1; w_max_q <= '0;
          end
          lhsm_pkg::OP_CLEAR: begin
            if (active_q) begin
              a_beg_q <= '0; a_good_q <= '0; a_bad_q <= '0; a_sum_q <= '0;
              a_min_q <= '1; a_max_q <= '0;
              w_beg_q <= '0; w_good_q <= '0; w_bad_q <= '0; w_sum_q <= '0;
              w_min_q <= '1; w_max_q <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q <= raddr;
    ci_q <= ri_q;
    if (accept) begin
      lat_q <= in_i.latency_ns;
    end
    if (state_q == lhsm_pkg::ST_IDLE) e_q <= top_bit(in_i.latency_ns);
    if (state_q == lhsm_pkg::ST_HRD) hidx_q <= hidx_d;
    if (accept) begin
      sel_win_q <= (op == lhsm_pkg::OP_SNAP_WIN);
      sel_act_q <= active_q;
      total_q   <= '0;
      cum_q     <= '0;
      snap_q.begin_count  <= s_beg;
      snap_q.good_count   <= s_good;
      snap_q.bad_count    <= s_bad;
      snap_q.in_flight    <= (s_beg > s_fin) ? s_beg - s_fin : '0;
      snap_q.min_latency  <= (s_min == '1) ? '0 : s_min;
      snap_q.max_latency  <= (op == lhsm_pkg::OP_SNAP_WIN) ? w_max_q : a_max_q;
      snap_q.latency_sum  <= (op == lhsm_pkg::OP_SNAP_WIN) ? w_sum_q : a_sum_q;
      snap_q.p99_bound_ns <= '0;
    end else begin
      if (rv_q && (state_q == lhsm_pkg::ST_SUM || state_q == lhsm_pkg::ST_SUM_TAIL)) begin
        total_q <= total_q + rdata_sel;
      end
      if (rv_q && (state_q == lhsm_pkg::ST_SRCH || state_q == lhsm_pkg::ST_SRCH_TAIL1)) begin
        cum_q <= cum_q + rdata_sel;
      end
    end
    if (hit) p99_q <= bucket_top(ci_q);
    if (out_load) begin
      out_q <= {snap_q[$bits(lhsm_pkg::result_t)-1:W], p99_final};
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.begin_count  = out_q.begin_count;
  assign out_o.good_count   = out_q.good_count;
  assign out_o.bad_count    = out_q.bad_count;
  assign out_o.in_flight    = out_q.in_flight;
  assign out_o.min_latency  = out_q.min_latency;
  assign out_o.max_latency  = out_q.max_latency;
  assign out_o.latency_sum  = out_q.latency_sum;
  assign out_o.p99_bound_ns = out_q.p99_bound_ns;

endmodule

// File: tb/sv/latency_histogram_stats_monitor_top_tb.sv
`timescale 1ns / 1ps

module latency_histogram_stats_monitor_top_tb;

  localparam int unsigned SubCnt  = 1 << lhsm_pkg::SubBucketBitsDef;
  localparam int unsigned NBucket = SubCnt * (65 - lhsm_pkg::SubBucketBitsDef);
  localparam logic [63:0] AllOnes = '1;
  localparam int unsigned SettleCycles = 2 * NBucket + 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lhsm_in_if  stim_if ();
  lhsm_out_if res_if ();

  latency_histogram_stats_monitor_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stim_if.sink),
    .out_o  (res_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state: tot_* all time, ivl_* current interval
  logic        mon_active;
  logic [63:0] tot_begins, tot_good, tot_bad, tot_sum, tot_min, tot_max;
  logic [63:0] ivl_begins, ivl_good, ivl_bad, ivl_sum, ivl_min, ivl_max;
  logic [63:0] tot_hist [NBucket];
  logic [63:0] ivl_hist [NBucket];

  lhsm_pkg::result_t pending_snaps [$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic int unsigned lat_bucket(logic [63:0] v);
    int e, sh;
    if (v < 64'(SubCnt)) return int'(v);
    e = 63;
    while (e > 0 && !v[e]) e--;
    sh = e - lhsm_pkg::SubBucketBitsDef;
    return SubCnt + sh * SubCnt + (int'(v >> sh) - SubCnt);
  endfunction

  function automatic logic [63:0] bucket_bound(int unsigned idx);
    int unsigned rel, e, sub;
    if (idx < SubCnt) return 64'(idx);
    rel = idx - SubCnt;
    e = rel / SubCnt + lhsm_pkg::SubBucketBitsDef;
    sub = rel % SubCnt;
    if (e >= 63 && sub == SubCnt - 1) return AllOnes;
    return (64'(SubCnt + sub + 1) << (e - lhsm_pkg::SubBucketBitsDef)) - 64'd1;
  endfunction

  function automatic logic [63:0] p99_bound(ref logic [63:0] h [NBucket]);
    logic [63:0] total, target, cum;
    total = '0;
    cum = '0;
    for (int i = 0; i < NBucket; i++) total += h[i];
    if (total == 0) return '0;
    target = 64'd99 * (total / 100) + (64'd99 * (total % 100) + 64'd99) / 100;
    for (int i = 0; i < NBucket; i++) begin
      cum += h[i];
      if (cum >= target) return bucket_bound(i);
    end
    return AllOnes;
  endfunction

  function automatic lhsm_pkg::result_t pack_snap(logic [63:0] b, g, bd, mn, mx, s, p);
    lhsm_pkg::result_t r;
    logic [63:0] fin;
    fin = g + bd;
    r.begin_count  = b;
    r.good_count   = g;
    r.bad_count    = bd;
    r.in_flight    = (b > fin) ? b - fin : '0;
    r.min_latency  = (mn == AllOnes) ? '0 : mn;
    r.max_latency  = mx;
    r.latency_sum  = s;
    r.p99_bound_ns = p;
    return r;
  endfunction

  task automatic clear_interval();
    ivl_begins = '0; ivl_good = '0; ivl_bad = '0; ivl_sum = '0;
    ivl_min = AllOnes; ivl_max = '0;
  endtask

  task automatic monitor_reset();
    mon_active = 1'b0;
    tot_begins = '0; tot_good = '0; tot_bad = '0; tot_sum = '0;
    tot_min = AllOnes; tot_max = '0;
    clear_interval();
    for (int i = 0; i < NBucket; i++) begin
      tot_hist[i] = '0;
      ivl_hist[i] = '0;
    end
  endtask

  task automatic monitor_apply(logic [2:0] op, logic [63:0] lat, logic bad);
    int unsigned b;
    logic [63:0] p;
    case (op)
      lhsm_pkg::OP_BEGIN: begin
        tot_begins++; ivl_begins++; mon_active = 1'b1;
      end
      lhsm_pkg::OP_END: begin
        if (bad) begin
          tot_bad++; ivl_bad++;
        end else begin
          if (lat < tot_min) tot_min = lat;
          if (lat > tot_max) tot_max = lat;
          if (lat < ivl_min) ivl_min = lat;
          if (lat > ivl_max) ivl_max = lat;
          tot_sum += lat; ivl_sum += lat;
          tot_good++; ivl_good++;
          if (mon_active) begin
            b = lat_bucket(lat);
            tot_hist[b]++;
            ivl_hist[b]++;
          end
        end
      end
      lhsm_pkg::OP_SNAP_ALL: begin
        p = mon_active ? p99_bound(tot_hist) : '0;
        pending_snaps.push_back(pack_snap(tot_begins, tot_good, tot_bad, tot_min, tot_max,
                                          tot_sum, p));
      end
      lhsm_pkg::OP_SNAP_WIN: begin
        p = '0;
        if (mon_active) begin
          p = p99_bound(ivl_hist);
          for (int i = 0; i < NBucket; i++) ivl_hist[i] = '0;
        end
        pending_snaps.push_back(pack_snap(ivl_begins, ivl_good, ivl_bad, ivl_min, ivl_max,
                                          ivl_sum, p));
        clear_interval();
      end
      lhsm_pkg::OP_CLEAR: begin
        if (mon_active) begin
          tot_begins = '0; tot_good = '0; tot_bad = '0; tot_sum = '0;
          tot_min = AllOnes; tot_max = '0;
          clear_interval();
          for (int i = 0; i < NBucket; i++) begin
            tot_hist[i] = '0;
            ivl_hist[i] = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [2:0] op, logic [63:0] lat, logic bad);
    while ($urandom_range(99) < send_idle_pct) begin
      stim_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    stim_if.valid      <= 1'b1;
    stim_if.operation  <= op;
    stim_if.latency_ns <= lat;
    stim_if.failed     <= bad;
    do @(posedge clk_i); while (!stim_if.ready);
    monitor_apply(op, lat, bad);
    @(negedge clk_i);
  endtask

  task automatic drain();
    stim_if.valid <= 1'b0;
    wait (pending_snaps.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_latency();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2: return 64'($urandom_range(40));
      3:       return AllOnes;
      4:       return v;
      default: return v >> $urandom_range(63);
    endcase
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    lhsm_pkg::result_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_snaps.size() == 0) begin
        $error("snapshot transfer with none expected");
        errors++;
      end else begin
        e = pending_snaps.pop_front();
        check_field("begin_count", e.begin_count, res_if.begin_count);
        check_field("good_count", e.good_count, res_if.good_count);
        check_field("bad_count", e.bad_count, res_if.bad_count);
        check_field("in_flight", e.in_flight, res_if.in_flight);
        check_field("min_latency", e.min_latency, res_if.min_latency);
        check_field("max_latency", e.max_latency, res_if.max_latency);
        check_field("latency_sum", e.latency_sum, res_if.latency_sum);
        check_field("p99_bound_ns", e.p99_bound_ns, res_if.p99_bound_ns);
      end
    end
  end

  task automatic test_inactive();
    send_item(lhsm_pkg::OP_SNAP_ALL, '0, 1'b0);
    send_item(lhsm_pkg::OP_END, 64'd7, 1'b0);
    send_item(lhsm_pkg::OP_END, '0, 1'b1);
    send_item(lhsm_pkg::OP_CLEAR, '0, 1'b0);
    send_item(lhsm_pkg::OP_SNAP_WIN, '0, 1'b0);
    send_item(3'd5, AllOnes, 1'b1);
    send_item(lhsm_pkg::OP_SNAP_ALL, '0, 1'b0);
  endtask

  task automatic test_extremes();
    send_item(lhsm_pkg::OP_BEGIN, AllOnes, 1'b1);
    send_item(lhsm_pkg::OP_END, '0, 1'b0);
    send_item(lhsm_pkg::OP_END, 64'd31, 1'b0);
    send_item(lhsm_pkg::OP_END, 64'd32, 1'b0);
    send_item(lhsm_pkg::OP_END, AllOnes, 1'b0);
    send_item(lhsm_pkg::OP_END, 64'h8000_0000_0000_0000, 1'b0);
    send_item(lhsm_pkg::OP_END, AllOnes, 1'b1);
    send_item(3'd6, '0, 1'b0);
    send_item(3'd7, '0, 1'b0);
    send_item(lhsm_pkg::OP_SNAP_ALL, '0, 1'b0);
    send_item(lhsm_pkg::OP_SNAP_WIN, '0, 1'b0);
    send_item(lhsm_pkg::OP_END, AllOnes, 1'b0);
    send_item(lhsm_pkg::OP_SNAP_WIN, '0, 1'b0);
    send_item(lhsm_pkg::OP_CLEAR, '0, 1'b0);
    send_item(lhsm_pkg::OP_SNAP_ALL, '0, 1'b0);
    send_item(lhsm_pkg::OP_SNAP_WIN, '0, 1'b0);
    drain();
  endtask

  task automatic test_random(int unsigned n_items, int unsigned s_pct, int unsigned r_pct);
    int unsigned k, sel;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    k = 0;
    while (k < n_items) begin
      sel = $urandom_range(999);
      if (sel < 330) send_item(lhsm_pkg::OP_BEGIN, rand_latency(), 1'($urandom_range(1)));
      else if (sel < 890) send_item(lhsm_pkg::OP_END, rand_latency(), $urandom_range(9) == 0);
      else if (sel < 920) begin
        send_item(lhsm_pkg::OP_SNAP_ALL, rand_latency(), 1'($urandom_range(1)));
      end else if (sel < 955) begin
        send_item(lhsm_pkg::OP_SNAP_WIN, rand_latency(), 1'($urandom_range(1)));
      end else if (sel < 970) begin
        send_item(lhsm_pkg::OP_CLEAR, rand_latency(), 1'($urandom_range(1)));
      end else begin
        send_item(3'($urandom_range(7, 5)), rand_latency(), 1'($urandom_range(1)));
        k--;
      end
      k++;
      if (sel == 500) drain();
    end
  endtask

  initial begin
    stim_if.valid      = 1'b0;
    stim_if.operation  = '0;
    stim_if.latency_ns = '0;
    stim_if.failed     = 1'b0;
    res_if.ready       = 1'b0;
    monitor_reset();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_inactive();
    test_extremes();
    test_random(310, 21, 61);
    drain();
    test_random(310, 61, 21);
    test_random(310, 0, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    if (errors == 0) $display("latency_histogram_stats_monitor_top_tb: clean");
    else $display("latency_histogram_stats_monitor_top_tb: errors");
    $finish;
  end

  initial begin
    #200ms;
    $display("latency_histogram_stats_monitor_top_tb: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/lhsm_pkg.sv
rtl/lhsm_in_if.sv
rtl/lhsm_out_if.sv
rtl/lhsm_ram.sv
rtl/latency_histogram_stats_monitor_top.sv
tb/sv/latency_histogram_stats_monitor_top_tb.sv
